// ===== sv/fpt_pkg.sv =====
`default_nettype none

package fpt_pkg;

    // Field widths of the words on the channels
    localparam int KIND_W     = 2;
    localparam int CH_FIELD_W = 3;
    localparam int DUTY_W     = 8;
    localparam int EDGE_W     = 8;
    localparam int MASK_W     = 8;
    localparam int RPM_W      = 16;

    // Register widths
    localparam int PPR_W = 4;
    localparam int WIN_W = 14;

    // Datapath widths
    localparam int CNT_W  = 32;
    localparam int ALU_W  = 32;
    localparam int DIV_W  = PPR_W + WIN_W;
    localparam int QUO_W  = RPM_W;
    localparam int BIT_W  = $clog2(QUO_W);
    localparam int NUM_W  = CNT_W + 16;

    // APB port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Most reports one window gives, and lanes of the pin mask
    localparam int MAX_LANES = 8;

    // Arithmetic constants
    localparam int unsigned RPM_SCALE  = 60 * 1000;
    localparam int unsigned ROUND_BIAS = 127;
    localparam int unsigned DUTY_FULL  = 255;
    localparam logic [RPM_W-1:0] RPM_SAT = 16'hffff;

    // Register reset values
    localparam logic             RST_DRIVE_ENABLE = 1'b0;
    localparam logic [PPR_W-1:0] RST_PPR          = 4'd2;
    localparam logic [WIN_W-1:0] RST_WINDOW_MS    = 14'd1000;

    typedef enum logic [KIND_W-1:0] {
        KIND_PWM_TICK   = 2'd0,
        KIND_TACH       = 2'd1,
        KIND_WINDOW_END = 2'd2,
        KIND_SET_DUTY   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_DRIVE_ENABLE   = 2'd0,
        REG_PULSES_PER_REV = 2'd1,
        REG_WINDOW_MS      = 2'd2
    } reg_addr_t;

    typedef enum logic {
        REPORT_MASK = 1'b0,
        REPORT_RPM  = 1'b1
    } report_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MASK,
        S_MASK_EMIT,
        S_TACH,
        S_WIN_SETUP,
        S_RPM_MUL,
        S_RPM_OVF,
        S_RPM_DIV,
        S_RPM_EMIT
    } state_t;

    typedef struct packed {
        logic             drive_enable;
        logic [PPR_W-1:0] pulses_per_rev;
        logic [WIN_W-1:0] window_ms;
    } cfg_t;

    typedef struct packed {
        alu_op_t          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             ge;
    } alu_rsp_t;

    typedef struct packed {
        logic                  report_type;
        logic [MASK_W-1:0]     low_mask;
        logic [CH_FIELD_W-1:0] rpm_channel;
        logic [RPM_W-1:0]      rpm;
        logic                  last;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/fpt_in_if.sv =====
`default_nettype none

interface fpt_in_if import fpt_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [CH_FIELD_W-1:0] channel;
    logic [DUTY_W-1:0]     duty;
    logic [EDGE_W-1:0]     tach_edges;

    modport source (output valid, kind, channel, duty, tach_edges, input ready);
    modport sink   (input valid, kind, channel, duty, tach_edges, output ready);

endinterface

`default_nettype wire

// ===== sv/fpt_out_if.sv =====
`default_nettype none

interface fpt_out_if import fpt_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic                  report_type;
    logic [MASK_W-1:0]     low_mask;
    logic [CH_FIELD_W-1:0] rpm_channel;
    logic [RPM_W-1:0]      rpm;
    logic                  last;

    modport source (output valid, report_type, low_mask, rpm_channel, rpm, last,
                    input ready);
    modport sink   (input valid, report_type, low_mask, rpm_channel, rpm, last,
                    output ready);

endinterface

`default_nettype wire

// ===== sv/fan_pwm_tach_controller.sv =====
// PWM tick: walks NL = min(CHANNELS, 8) lanes, one threshold compare a cycle on the shared
//   subtractor, then offers the mask word.
// Tach word: at most one counter increment a cycle over the lanes; a set-duty word is written on accept.
// Window end: divisor setup, then per lane multiply, range check, up to 16 divide steps, report.
// Not ready while a word is in work; the output register holds a finished word meanwhile.
// rst_n (asynchronous, active low) clears duties, counters, wave step and registers.
`default_nettype none

module fan_pwm_tach_controller import fpt_pkg::*; #(
    parameter int CHANNELS   = 8,
    parameter int WAVE_STEPS = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    fpt_in_if.sink                 item_in,
    fpt_out_if.source              result_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    cfg_t     cfg;
    alu_req_t alu_req;
    alu_rsp_t alu_rsp;
    logic     emit_valid;
    res_t     emit_word;
    logic     out_free;
    logic     out_valid_reg;
    res_t     out_word_reg;

    fpt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fpt_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    fpt_seq #(
        .CHANNELS   (CHANNELS),
        .WAVE_STEPS (WAVE_STEPS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .cfg        (cfg),
        .alu_req    (alu_req),
        .alu_rsp    (alu_rsp),
        .emit_valid (emit_valid),
        .emit_word  (emit_word),
        .out_free   (out_free)
    );

    assign out_free = !out_valid_reg || result_out.ready;

    // Hold the result word until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_valid && out_free)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid && out_free)
            out_word_reg <= emit_word;
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.report_type = out_word_reg.report_type;
    assign result_out.low_mask    = out_word_reg.low_mask;
    assign result_out.rpm_channel = out_word_reg.rpm_channel;
    assign result_out.rpm         = out_word_reg.rpm;
    assign result_out.last        = out_word_reg.last;

endmodule

`default_nettype wire

// ===== sv/fpt_cfg.sv =====
`default_nettype none

module fpt_cfg import fpt_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic             drive_enable_reg;
    logic [PPR_W-1:0] ppr_reg;
    logic [WIN_W-1:0] window_ms_reg;
    reg_addr_t        reg_sel;

    assign reg_sel = reg_addr_t'(paddr[3:2]);
    assign pready  = 1'b1;

    // Take a write in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_enable_reg <= RST_DRIVE_ENABLE;
            ppr_reg          <= RST_PPR;
            window_ms_reg    <= RST_WINDOW_MS;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_DRIVE_ENABLE:   drive_enable_reg <= pwdata[0];
                REG_PULSES_PER_REV: ppr_reg          <= pwdata[PPR_W-1:0];
                REG_WINDOW_MS:      window_ms_reg    <= pwdata[WIN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Read back the selected register
    always_comb
    begin
        unique case (reg_sel)
            REG_DRIVE_ENABLE:   prdata = APB_DW'(drive_enable_reg);
            REG_PULSES_PER_REV: prdata = APB_DW'(ppr_reg);
            REG_WINDOW_MS:      prdata = APB_DW'(window_ms_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.drive_enable   = drive_enable_reg;
    assign cfg.pulses_per_rev = ppr_reg;
    assign cfg.window_ms      = window_ms_reg;

endmodule

`default_nettype wire

// ===== sv/fpt_alu.sv =====
`default_nettype none

module fpt_alu import fpt_pkg::*; (
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ALU_W:0] diff;

    // One subtractor serves compares and the restoring subtract; increments use the adder
    assign diff = {1'b0, req.a} - {1'b0, req.b};

    always_comb
    begin
        case (req.op)
            ALU_ADD: rsp.res = req.a + req.b;
            default: rsp.res = diff[ALU_W-1:0];
        endcase
        rsp.ge = ~diff[ALU_W];
    end

endmodule

`default_nettype wire

// ===== sv/fpt_seq.sv =====
`default_nettype none

module fpt_seq import fpt_pkg::*; #(
    parameter int CHANNELS   = 8,
    parameter int WAVE_STEPS = 256
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fpt_in_if.sink    item_in,
    input  cfg_t      cfg,
    output alu_req_t  alu_req,
    input  alu_rsp_t  alu_rsp,
    output logic      emit_valid,
    output res_t      emit_word,
    input  wire logic out_free
);

    localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int STEP_W = $clog2(WAVE_STEPS);
    localparam int NLANE  = (CHANNELS < MAX_LANES) ? CHANNELS : MAX_LANES;

    state_t state_reg, state_next;

    logic [CH_FIELD_W-1:0] ch_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DUTY_W-1:0]     duty_reg  [CHANNELS];
    logic [CNT_W-1:0]      count_reg [CHANNELS];

    logic [MASK_W-1:0] mask_reg;
    logic [EDGE_W-1:0] edges_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [BIT_W-1:0]  bit_reg;

    logic              accept;
    logic              last_ch;
    logic [CW-1:0]     ch_idx;
    logic [CW-1:0]     wr_idx;
    logic              wr_ok;
    logic [DUTY_W-1:0] duty_eff;
    logic [ALU_W-1:0]  mark_val;
    logic [ALU_W-1:0]  span;
    logic [ALU_W-1:0]  span_scaled;
    logic [QUO_W-1:0]  num_lo;
    logic [DIV_W:0]    shifted;
    logic [PPR_W-1:0]  ppr_eff;
    logic [WIN_W-1:0]  win_eff;
    logic [STEP_W-1:0] step_inc;

    assign item_in.ready = (state_reg == S_IDLE);
    assign accept        = item_in.valid && item_in.ready;
    assign last_ch       = (ch_reg == CH_FIELD_W'(NLANE - 1));
    assign ch_idx        = CW'(ch_reg);
    assign wr_idx        = CW'(item_in.channel);
    assign wr_ok         = (32'(item_in.channel) < 32'(CHANNELS));

    // Pin is low while duty*W+127 < 255*(W-step), the threshold test without a divide
    assign duty_eff    = cfg.drive_enable ? duty_reg[ch_idx] : '0;
    assign mark_val    = ALU_W'(duty_eff) * ALU_W'(WAVE_STEPS) + ALU_W'(ROUND_BIAS);
    assign span        = ALU_W'(WAVE_STEPS) - ALU_W'(step_reg);
    assign span_scaled = span * ALU_W'(DUTY_FULL);

    // Restoring division: bring down one numerator bit a step
    assign num_lo  = num_reg[QUO_W-1:0];
    assign shifted = {rem_reg, num_lo[bit_reg]};

    // Zero divisors count as one
    assign ppr_eff = (cfg.pulses_per_rev == '0) ? PPR_W'(1) : cfg.pulses_per_rev;
    assign win_eff = (cfg.window_ms == '0) ? WIN_W'(1) : cfg.window_ms;

    assign step_inc = (step_reg == STEP_W'(WAVE_STEPS - 1)) ? '0 : step_reg + 1'b1;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state, unit operands and result word
    always_comb
    begin
        state_next  = state_reg;
        alu_req.op  = ALU_SUB;
        alu_req.a   = '0;
        alu_req.b   = '0;
        emit_valid  = 1'b0;
        emit_word   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind_t'(item_in.kind))
                        KIND_PWM_TICK:   state_next = S_MASK;
                        KIND_TACH:       state_next = S_TACH;
                        KIND_WINDOW_END: state_next = S_WIN_SETUP;
                        KIND_SET_DUTY:   state_next = S_IDLE;
                        default:         state_next = S_IDLE;
                    endcase
                end
            end
            S_MASK:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = mark_val;
                alu_req.b  = span_scaled;
                if (last_ch)
                    state_next = S_MASK_EMIT;
            end
            S_MASK_EMIT:
            begin
                emit_valid            = 1'b1;
                emit_word.report_type = REPORT_MASK;
                emit_word.low_mask    = mask_reg;
                if (out_free)
                    state_next = S_IDLE;
            end
            S_TACH:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = count_reg[ch_idx];
                alu_req.b  = ALU_W'(1);
                if (last_ch)
                    state_next = S_IDLE;
            end
            S_WIN_SETUP:
                state_next = S_RPM_MUL;
            S_RPM_MUL:
                state_next = S_RPM_OVF;
            S_RPM_OVF:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = num_reg[NUM_W-1:QUO_W];
                alu_req.b  = ALU_W'(div_reg);
                state_next = alu_rsp.ge ? S_RPM_EMIT : S_RPM_DIV;
            end
            S_RPM_DIV:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_W'(shifted);
                alu_req.b  = ALU_W'(div_reg);
                if (bit_reg == '0)
                    state_next = S_RPM_EMIT;
            end
            S_RPM_EMIT:
            begin
                emit_valid            = 1'b1;
                emit_word.report_type = REPORT_RPM;
                emit_word.rpm_channel = ch_reg;
                emit_word.rpm         = quo_reg;
                emit_word.last        = last_ch;
                if (out_free)
                    state_next = last_ch ? S_IDLE : S_RPM_MUL;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Channel walk, wave step, duties and pulse counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg   <= '0;
            step_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                duty_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ch_reg <= '0;
                        if (kind_t'(item_in.kind) == KIND_SET_DUTY && wr_ok)
                            duty_reg[wr_idx] <= item_in.duty;
                    end
                end
                S_MASK:
                begin
                    if (!last_ch)
                        ch_reg <= ch_reg + 1'b1;
                end
                S_MASK_EMIT:
                begin
                    if (out_free)
                        step_reg <= step_inc;
                end
                S_TACH:
                begin
                    if (edges_reg[ch_reg])
                        count_reg[ch_idx] <= alu_rsp.res;
                    if (!last_ch)
                        ch_reg <= ch_reg + 1'b1;
                end
                S_RPM_EMIT:
                begin
                    if (out_free)
                    begin
                        if (last_ch)
                        begin
                            for (int i = 0; i < CHANNELS; i++)
                                count_reg[i] <= '0;
                        end
                        else
                            ch_reg <= ch_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers of the mask walk and the divider
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mask_reg  <= '0;
                    edges_reg <= item_in.tach_edges;
                end
            end
            S_MASK:
                mask_reg[ch_reg] <= ~alu_rsp.ge;
            S_WIN_SETUP:
                div_reg <= DIV_W'(ppr_eff) * DIV_W'(win_eff);
            S_RPM_MUL:
                num_reg <= NUM_W'(count_reg[ch_idx]) * NUM_W'(RPM_SCALE);
            S_RPM_OVF:
            begin
                // Quotient past 16 bits: saturate, else the high part is below the divisor
                if (alu_rsp.ge)
                    quo_reg <= RPM_SAT;
                rem_reg <= num_reg[QUO_W+DIV_W-1:QUO_W];
                bit_reg <= BIT_W'(QUO_W - 1);
            end
            S_RPM_DIV:
            begin
                rem_reg <= alu_rsp.ge ? alu_rsp.res[DIV_W-1:0] : shifted[DIV_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], alu_rsp.ge};
                bit_reg <= bit_reg - 1'b1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/fpt_checker.sv =====
`default_nettype none

module fpt_checker import fpt_pkg::*; (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic [KIND_W-1:0]     in_kind,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic                  out_report_type,
    input wire logic [MASK_W-1:0]     out_low_mask,
    input wire logic [CH_FIELD_W-1:0] out_rpm_channel,
    input wire logic [RPM_W-1:0]      out_rpm,
    input wire logic                  out_last
);

    // A stalled result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word withdrawn while stalled");

    // A stalled result word keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_report_type) && $stable(out_low_mask)
            && $stable(out_rpm_channel) && $stable(out_rpm) && $stable(out_last))
        else $error("result word changed while stalled");

    // Any word but a duty write keeps the sequencer busy next cycle
    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_kind != KIND_SET_DUTY |=> !in_ready)
        else $error("input taken again straight after a multi-cycle word");

    // A window is not finished while a non-final speed report is pending
    a_window_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_report_type == REPORT_RPM && !out_last |-> !in_ready)
        else $error("input ready in the middle of a speed window");

endmodule

bind fan_pwm_tach_controller fpt_checker u_fpt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (item_in.valid),
    .in_ready        (item_in.ready),
    .in_kind         (item_in.kind),
    .out_valid       (result_out.valid),
    .out_ready       (result_out.ready),
    .out_report_type (result_out.report_type),
    .out_low_mask    (result_out.low_mask),
    .out_rpm_channel (result_out.rpm_channel),
    .out_rpm         (result_out.rpm),
    .out_last        (result_out.last)
);

`default_nettype wire
